>>> rtl/core/chd_pkg.sv
// Package for the canonical Huffman decoder: request and result structs,
// mode and status codes, and the build sequencer states. No dependencies.
`default_nettype none
package chd_pkg;
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_BUILD  = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_BADLEN  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol_index;
        logic [7:0] code_length;
        logic       code_bit;
    } t_req;

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic [1:0] status;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_FIRST,
        S_PLACE,
        S_LOOK,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/canonical_huffman_decoder_unit.sv
// Top level of the canonical Huffman decoder: length memory, sorted symbol
// memory, per-length tables, build sequencer and bit decoder. Uses chd_pkg.
`default_nettype none
// A load request (mode 0), a request with the unused mode, and a decode request
// (mode 2) whose bit completes no code present their result the cycle after
// acceptance. A decode request whose bit completes a code goes further: the
// slot's symbol is first read from the sorted-symbol memory through its
// registered read port, and the result is registered after that. A build request
// (mode 1) walks the length memory to count lengths, works out the first code and
// slot of each length, then walks the length memory once per length to place
// symbols, and ends in a closing state that presents its result.
// Each request gives one result held in an output register; the next request
// is accepted the cycle after that result has been taken. No clearing pass: the
// length memory starts valid through per-entry valid bits.
module canonical_huffman_decoder_unit #(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  chd_pkg::t_req        i_req,
    output logic                 o_valid,
    input  wire                  i_stall,
    output chd_pkg::t_res        o_res
);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int CW = MAX_CODE_LEN;
    localparam int SW = $clog2(NUM_SYMBOLS + 1);
    localparam int IW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int NL = MAX_CODE_LEN + 1;

    // memories
    logic [LW-1:0] len_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_len_ok;
    logic [7:0] sym_mem [256];
    logic [LW-1:0] r_len_rd;
    logic [7:0] r_sym_rd;

    // first codes carry one extra bit: set means the code is out of reach
    logic [CW:0]   r_first_code [NL];
    logic [SW-1:0] r_count [NL];
    logic [SW-1:0] r_first_slot [NL];

    logic [CW-1:0] r_acc, n_acc;
    logic [LW-1:0] r_bits, n_bits;

    chd_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_slot, n_slot;
    logic [CW:0]   r_code, n_code;
    logic          r_busy, n_busy;
    logic          r_dec, n_dec;
    logic          r_ovalid, n_ovalid;
    chd_pkg::t_res r_res, n_res;

    logic          len_we;
    logic [IW-1:0] len_wa;
    logic [LW-1:0] len_wd;
    logic [IW-1:0] len_ra;
    logic          sym_we;
    logic [7:0]    sym_wa;
    logic [7:0]    sym_wd;
    logic [7:0]    sym_ra;
    logic          cnt_inc, cnt_clr;
    logic          first_we;
    logic          rd_ok;
    logic [LW-1:0] rd_len;
    logic [CW:0]   code_sum;
    logic          accept;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_busy || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign rd_ok   = r_len_ok[len_ra];

    // length memory: registered read, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_wa] <= len_wd;
        end
        r_len_rd <= len_mem[len_ra];
    end
    logic r_rd_ok;
    always_ff @(posedge i_clk) begin
        r_rd_ok <= rd_ok;
        if (!i_rst_n) begin
            r_len_ok <= '0;
        end else if (len_we) begin
            r_len_ok[len_wa] <= 1'b1;
        end
    end
    assign rd_len = r_rd_ok ? r_len_rd : '0;

    // sorted-symbol memory
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            sym_mem[sym_wa] <= sym_wd;
        end
        r_sym_rd <= sym_mem[sym_ra];
    end

    // per-length tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_count[k]      <= '0;
                r_first_code[k] <= '0;
                r_first_slot[k] <= '0;
            end
        end else begin
            if (cnt_clr) begin
                for (int k = 0; k < NL; k++) begin
                    r_count[k] <= '0;
                end
            end else if (cnt_inc) begin
                r_count[rd_len] <= r_count[rd_len] + SW'(1);
            end
            if (first_we) begin
                r_first_code[r_len] <= n_code;
                r_first_slot[r_len] <= r_idx;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= chd_pkg::S_IDLE;
            r_busy   <= 1'b0;
            r_dec    <= 1'b0;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_bits   <= '0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_dec    <= n_dec;
            r_ovalid <= n_ovalid;
            r_acc    <= n_acc;
            r_bits   <= n_bits;
        end
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_slot <= n_slot;
        r_code <= n_code;
        r_res  <= n_res;
    end

    // running code plus the count of the previous length
    assign code_sum = {1'b0, r_code[CW-1:0]} + (CW+1)'(r_count[r_len - LW'(1)]);

    // decode lookup terms
    logic [CW-1:0] d_acc;
    logic [LW-1:0] d_bits;
    logic [CW-1:0] d_off;
    logic          d_hit;
    always_comb begin
        d_acc  = {r_acc[CW-2:0], i_req.code_bit};
        d_bits = (r_bits < LW'(MAX_CODE_LEN)) ? r_bits + LW'(1) : r_bits;
        d_off  = d_acc - r_first_code[d_bits][CW-1:0];
        d_hit  = ({1'b0, d_acc} >= r_first_code[d_bits]) &&
                 (d_off < CW'(r_count[d_bits]));
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_dec    = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        n_res    = r_res;
        n_acc    = r_acc;
        n_bits   = r_bits;
        n_idx    = r_idx;
        n_len    = r_len;
        n_slot   = r_slot;
        n_code   = r_code;
        len_we   = 1'b0;
        len_wa   = i_req.symbol_index[IW-1:0];
        len_wd   = i_req.code_length[LW-1:0];
        len_ra   = r_idx[IW-1:0];
        sym_we   = 1'b0;
        sym_wa   = r_slot;
        sym_wd   = 8'(r_idx - SW'(1));
        sym_ra   = r_slot;
        cnt_inc  = 1'b0;
        cnt_clr  = 1'b0;
        first_we = 1'b0;

        // finish a decode: symbol read is back
        if (r_dec) begin
            n_res.symbol = r_sym_rd;
            n_ovalid     = 1'b1;
            n_busy       = 1'b0;
        end

        case (r_state)
            chd_pkg::S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    case (i_req.mode)
                        chd_pkg::MODE_LOAD: begin
                            if (i_req.code_length > 8'(MAX_CODE_LEN)) begin
                                n_res.status = chd_pkg::ST_BADLEN;
                            end else if ({1'b0, i_req.symbol_index} < 9'(NUM_SYMBOLS)) begin
                                len_we = 1'b1;
                            end
                            n_ovalid = 1'b1;
                        end
                        chd_pkg::MODE_BUILD: begin
                            n_busy  = 1'b1;
                            cnt_clr = 1'b1;
                            n_idx   = '0;
                            n_state = chd_pkg::S_COUNT;
                        end
                        chd_pkg::MODE_DECODE: begin
                            if (d_hit) begin
                                sym_ra = 8'(r_first_slot[d_bits] + SW'(d_off));
                                n_res.symbol_valid = 1'b1;
                                n_acc  = '0;
                                n_bits = '0;
                                n_busy = 1'b1;
                                n_dec  = 1'b1;
                            end else begin
                                if (d_bits >= LW'(MAX_CODE_LEN)) begin
                                    n_res.status = chd_pkg::ST_OVERRUN;
                                    n_acc  = '0;
                                    n_bits = '0;
                                end else begin
                                    n_acc  = d_acc;
                                    n_bits = d_bits;
                                end
                                n_ovalid = 1'b1;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            // count lengths: read address r_idx, data back through the registered read port
            chd_pkg::S_COUNT: begin
                if (r_idx != '0 && rd_len != '0) begin
                    cnt_inc = 1'b1;
                end
                if (r_idx == SW'(NUM_SYMBOLS)) begin
                    n_state = chd_pkg::S_FIRST;
                    n_len   = LW'(1);
                    n_code  = '0;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            // first code and slot per length; r_idx holds the running slot;
            // a code that outgrows MAX_CODE_LEN bits saturates and never matches
            chd_pkg::S_FIRST: begin
                if (r_code[CW] || code_sum[CW:CW-1] != 2'b00) begin
                    n_code = {1'b1, {CW{1'b0}}};
                end else begin
                    n_code = {code_sum[CW-1:0], 1'b0};
                end
                first_we = 1'b1;
                n_idx    = r_idx + r_count[r_len];
                if (r_len == LW'(MAX_CODE_LEN)) begin
                    n_state = chd_pkg::S_PLACE;
                    n_len   = LW'(1);
                    n_idx   = '0;
                    n_slot  = '0;
                end else begin
                    n_len = r_len + LW'(1);
                end
            end
            // place symbols of length r_len in order
            chd_pkg::S_PLACE: begin
                if (r_idx != '0 && rd_len == r_len) begin
                    sym_we = 1'b1;
                    n_slot = r_slot + 8'd1;
                end
                if (r_idx == SW'(NUM_SYMBOLS)) begin
                    n_idx = '0;
                    if (r_len == LW'(MAX_CODE_LEN)) begin
                        n_state = chd_pkg::S_DONE;
                    end else begin
                        n_len = r_len + LW'(1);
                    end
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            chd_pkg::S_DONE: begin
                n_acc    = '0;
                n_bits   = '0;
                n_busy   = 1'b0;
                n_ovalid = 1'b1;
                n_state  = chd_pkg::S_IDLE;
            end
            default: begin
                n_state = chd_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
